@@ rtl/mgd_pkg.sv @@
package mgd_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 40;
    localparam int QUEUE_DEPTH = 2;

    // register map
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRAVITY    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PEAKS      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LIFT       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_REARM      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_COOLDOWN   = 3'd6;

    // gesture codes
    localparam logic [1:0] GEST_NONE  = 2'd0;
    localparam logic [1:0] GEST_SHAKE = 2'd1;
    localparam logic [1:0] GEST_LIFT  = 2'd2;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [13:0] motion_threshold_lsb;
        logic [13:0] gravity_lsb;
        logic [31:0] shake_window_us;
        logic [3:0]  shake_peaks_needed;
        logic [7:0]  lift_samples_needed;
        logic [7:0]  still_samples_rearm;
        logic [39:0] cooldown_us;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        motion_threshold_lsb: 14'd1229,
        gravity_lsb:          14'd4096,
        shake_window_us:      32'd1000000,
        shake_peaks_needed:   4'd2,
        lift_samples_needed:  8'd5,
        still_samples_rearm:  8'd50,
        cooldown_us:          40'd300000000
    };

endpackage

@@ rtl/mgd_fifo.sv @@
module mgd_fifo #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");

endmodule

@@ rtl/mgd_front.sv @@
module mgd_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mgd_pkg::cfg_t          cfg,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_x,
    input  logic [SAMPLE_BITS-1:0] s_y,
    input  logic [SAMPLE_BITS-1:0] s_z,
    input  logic [TIME_BITS-1:0]   s_now,
    input  logic                   s_supp,
    output logic                   push,
    output logic [TIME_BITS+1:0]   push_data,
    input  logic                   full
);
    import mgd_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int OP_W  = (SB > 15) ? SB : 15;
    localparam int SQ_W  = 2 * OP_W;
    localparam int SUM_W = SQ_W + 2;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_SQD  = 3'd1;  // squares of the deltas
    localparam logic [2:0] F_SQM  = 3'd2;  // squares of the axes
    localparam logic [2:0] F_SQT  = 3'd3;  // squares of the bounds
    localparam logic [2:0] F_CMP  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       accept;
    logic       moving;

    logic [2:0][SB-1:0] axis;
    logic [2:0][SB-1:0] prev_reg;
    logic               prev_valid_reg;
    logic [2:0][SB-1:0] dabs, sabs;
    logic [2:0][SB-1:0] dabs_reg, sabs_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic               supp_reg;
    logic               fv_reg;

    logic [2:0][OP_W-1:0] op;
    logic [2:0][SQ_W-1:0] prod, prod_reg;
    logic [SUM_W-1:0]     prod_sum;
    logic [SUM_W-1:0]     d2_reg, mag2_reg;

    logic [14:0] hi;
    logic [13:0] lo;

    assign axis   = {s_z, s_y, s_x};
    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == F_IDLE) || (state_reg == F_CMP && !full);

    assign hi = {1'b0, cfg.gravity_lsb} + {1'b0, cfg.motion_threshold_lsb};
    assign lo = cfg.gravity_lsb - cfg.motion_threshold_lsb;

    always_comb begin
        logic signed [SB:0] d;
        logic signed [SB:0] a;
        for (int k = 0; k < 3; k++) begin
            d = $signed({axis[k][SB-1], axis[k]}) - $signed({prev_reg[k][SB-1], prev_reg[k]});
            dabs[k] = d[SB] ? SB'(-d) : d[SB-1:0];
            a = $signed({axis[k][SB-1], axis[k]});
            sabs[k] = a[SB] ? SB'(-a) : a[SB-1:0];
        end
    end

    always_comb begin
        case (state_reg)
            F_SQD: begin
                for (int k = 0; k < 3; k++) op[k] = OP_W'(dabs_reg[k]);
            end
            F_SQM: begin
                for (int k = 0; k < 3; k++) op[k] = OP_W'(sabs_reg[k]);
            end
            default: begin
                op[0] = OP_W'(cfg.motion_threshold_lsb);
                op[1] = OP_W'(hi);
                op[2] = OP_W'(lo);
            end
        endcase
        for (int k = 0; k < 3; k++) begin
            prod[k] = SQ_W'(op[k]) * SQ_W'(op[k]);
        end
    end

    assign prod_sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);

    // prod_reg holds thr^2, hi^2, lo^2 in F_CMP
    assign moving = (fv_reg && d2_reg > SUM_W'(prod_reg[0]))
                 || (mag2_reg > SUM_W'(prod_reg[1]))
                 || ((cfg.gravity_lsb > cfg.motion_threshold_lsb)
                     && (mag2_reg < SUM_W'(prod_reg[2])));

    assign push      = (state_reg == F_CMP) && !full;
    assign push_data = {now_reg, supp_reg, moving};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) state_next = F_SQD;
            end
            F_SQD: state_next = F_SQM;
            F_SQM: state_next = F_SQT;
            F_SQT: state_next = F_CMP;
            F_CMP: begin
                if (!full) state_next = accept ? F_SQD : F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= F_IDLE;
            prev_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) prev_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod;
        if (state_reg == F_SQM) d2_reg <= prod_sum;
        if (state_reg == F_SQT) mag2_reg <= prod_sum;
        if (accept) begin
            dabs_reg <= dabs;
            sabs_reg <= sabs;
            prev_reg <= axis;
            now_reg  <= s_now;
            supp_reg <= s_supp;
            fv_reg   <= prev_valid_reg;
        end
    end

    a_push_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> $past(state_reg) == F_SQT || $past(state_reg) == F_CMP)
        else $error("push before squares are done");
    a_first_no_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !prev_valid_reg) |=> !fv_reg)
        else $error("first beat used a delta");
    a_accept_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_CMP && full) |-> !s_ready)
        else $error("beat taken while result blocked");

endmodule

@@ rtl/mgd_back.sv @@
module mgd_back #(
    parameter int PEAK_SLOTS = 8,
    parameter int TIME_BITS  = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mgd_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    input  logic [TIME_BITS+1:0] q_data,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_gesture,
    output logic                 m_moving
);
    import mgd_pkg::*;

    localparam int TB     = TIME_BITS;
    localparam int SLOT_W = $clog2(PEAK_SLOTS);
    localparam int CNT_W  = $clog2(PEAK_SLOTS + 1);
    localparam int NEED_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int CMP_W  = (TB > 40) ? TB : 40;

    localparam logic [1:0] B_GATE = 2'd0;
    localparam logic [1:0] B_SCAN = 2'd1;
    localparam logic [1:0] B_DEC  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [7:0]            still_reg, still_next;
    logic [7:0]            lift_reg, lift_next;
    logic                  armed_reg, armed_next;
    logic [PEAK_SLOTS-1:0] pvalid_reg, pvalid_next;
    logic [TB-1:0]         ptime_reg [PEAK_SLOTS];
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [TB-1:0]         last_reg;
    logic                  trig_valid_reg, trig_valid_next;
    logic [TB-1:0]         now_reg;
    logic [PEAK_SLOTS-1:0] win_reg, win_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_gest_reg, out_gest_next;
    logic                  out_mv_reg, out_mv_next;

    logic          h_mv, h_sup;
    logic [TB-1:0] h_now;
    logic [TB-1:0] elapsed;
    logic          cool, allowed, out_free, store_peak, trigger;
    logic [7:0]    still_inc, lift_inc;
    logic [CNT_W-1:0] peaks;
    logic          shake, lift_hit;

    assign h_mv  = q_data[0];
    assign h_sup = q_data[1];
    assign h_now = q_data[TB+1:2];

    assign elapsed  = h_now - last_reg;
    assign cool     = trig_valid_reg && (CMP_W'(elapsed) < CMP_W'(cfg.cooldown_us));
    assign allowed  = !h_sup && armed_reg && !cool;
    assign out_free = !out_valid_reg || m_ready;

    assign still_inc = (still_reg == COUNT_MAX) ? still_reg : still_reg + 8'd1;
    assign lift_inc  = (lift_reg == COUNT_MAX) ? lift_reg : lift_reg + 8'd1;
    assign peaks     = CNT_W'($countones(win_reg));
    assign shake     = NEED_W'(peaks) >= NEED_W'(cfg.shake_peaks_needed);
    assign lift_hit  = lift_inc >= cfg.lift_samples_needed;

    assign store_peak = (state_reg == B_GATE) && q_valid && h_mv && allowed;
    assign trigger    = (state_reg == B_DEC) && out_free && (shake || lift_hit);

    always_comb begin
        logic [TB-1:0] age;
        state_next      = state_reg;
        still_next      = still_reg;
        lift_next       = lift_reg;
        armed_next      = armed_reg;
        pvalid_next     = pvalid_reg;
        slot_next       = slot_reg;
        trig_valid_next = trig_valid_reg;
        win_next        = win_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_gest_next   = out_gest_reg;
        out_mv_next     = out_mv_reg;
        q_pop           = 1'b0;
        age             = '0;
        case (state_reg)
            B_GATE: begin
                if (q_valid) begin
                    if (!h_mv) begin
                        if (out_free) begin
                            still_next = still_inc;
                            if (still_inc >= cfg.still_samples_rearm) armed_next = 1'b1;
                            lift_next      = 8'd0;
                            pvalid_next    = '0;
                            out_valid_next = 1'b1;
                            out_gest_next  = GEST_NONE;
                            out_mv_next    = 1'b0;
                            q_pop          = 1'b1;
                        end
                    end else if (!allowed) begin
                        if (out_free) begin
                            still_next     = 8'd0;
                            out_valid_next = 1'b1;
                            out_gest_next  = GEST_NONE;
                            out_mv_next    = 1'b1;
                            q_pop          = 1'b1;
                        end
                    end else begin
                        still_next            = 8'd0;
                        pvalid_next[slot_reg] = 1'b1;
                        slot_next = (slot_reg == SLOT_W'(PEAK_SLOTS - 1)) ? '0
                                                                          : slot_reg + 1'b1;
                        q_pop      = 1'b1;
                        state_next = B_SCAN;
                    end
                end
            end
            B_SCAN: begin
                for (int i = 0; i < PEAK_SLOTS; i++) begin
                    age         = now_reg - ptime_reg[i];
                    win_next[i] = pvalid_reg[i] && (age < TB'(cfg.shake_window_us));
                end
                state_next = B_DEC;
            end
            B_DEC: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_mv_next    = 1'b1;
                    if (shake) begin
                        armed_next      = 1'b0;
                        lift_next       = 8'd0;
                        trig_valid_next = 1'b1;
                        pvalid_next     = '0;
                        out_gest_next   = GEST_SHAKE;
                    end else if (lift_hit) begin
                        armed_next      = 1'b0;
                        lift_next       = 8'd0;
                        trig_valid_next = 1'b1;
                        out_gest_next   = GEST_LIFT;
                    end else begin
                        lift_next     = lift_inc;
                        out_gest_next = GEST_NONE;
                    end
                    state_next = B_GATE;
                end
            end
            default: state_next = B_GATE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_GATE;
            still_reg      <= 8'd0;
            lift_reg       <= 8'd0;
            armed_reg      <= 1'b1;
            pvalid_reg     <= '0;
            slot_reg       <= '0;
            trig_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            still_reg      <= still_next;
            lift_reg       <= lift_next;
            armed_reg      <= armed_next;
            pvalid_reg     <= pvalid_next;
            slot_reg       <= slot_next;
            trig_valid_reg <= trig_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg      <= win_next;
        out_gest_reg <= out_gest_next;
        out_mv_reg   <= out_mv_next;
        if (store_peak) begin
            ptime_reg[slot_reg] <= h_now;
            now_reg             <= h_now;
        end
        if (trigger) last_reg <= now_reg;
    end

    assign m_valid   = out_valid_reg;
    assign m_gesture = out_gest_reg;
    assign m_moving  = out_mv_reg;

    a_gesture_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_gest_reg != GEST_NONE) |-> out_mv_reg)
        else $error("gesture on a still beat");
    a_trigger_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        trigger |=> !armed_reg && trig_valid_reg && lift_reg == 8'd0)
        else $error("trigger left detector armed");
    a_still_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_GATE && q_valid && !h_mv && out_free)
        |=> pvalid_reg == '0 && lift_reg == 8'd0)
        else $error("still beat left peaks or lift count");
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg && $stable(out_gest_reg))
        else $error("stalled result overwritten");

endmodule

@@ rtl/motion_gesture_detector.sv @@
// Shake / lift detector for raw 3-axis accelerometer samples.
//
// s_* : one sample per beat (x, y, z, timestamp in us; tuser = suppress).
// m_* : exactly one result per sample, in order (gesture code, moving flag).
// cfg_*: register writes (cfg_addr = register index); always ready. Write
//        only while no sample is in flight.
//
// The front end takes a sample, squares deltas, axes and bounds on three
// shared multipliers and classifies it as moving or still; it takes the
// next sample while it pushes the result, unless the queue is full. A
// two-entry queue feeds the back end, which updates the arming, lift and
// peak state: a still or blocked sample is handled in the gate state, and a
// stored peak goes through ring write, window check of all peak slots, and
// count and decision.
// Results sit in an output register; when m_tready is low the back end, then
// the queue, then s_tready stall, and no result is dropped.
// Reset clears all counters, empties the peak ring, arms the detector, drops
// the previous sample and loads the register defaults.
module motion_gesture_detector #(
    parameter int PEAK_SLOTS  = 8,
    parameter int TIME_BITS   = 48,
    parameter int SAMPLE_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    // accel_x, accel_y, accel_z, now_us, zero pad to bytes
    input  logic [((3*SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
    // suppressed
    input  logic [0:0] s_tuser,

    output logic m_tvalid,
    input  logic m_tready,
    // gesture [1:0], zero pad
    output logic [7:0] m_tdata,
    // moving
    output logic [0:0] m_tuser,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mgd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mgd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mgd_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int TB = TIME_BITS;

    cfg_t cfg_reg;

    logic          push, full, pop, q_valid;
    logic [TB+1:0] push_data, pop_data;
    logic [1:0]    gesture;
    logic          moving;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_THRESHOLD: cfg_reg.motion_threshold_lsb <= cfg_data[13:0];
                REG_GRAVITY:   cfg_reg.gravity_lsb          <= cfg_data[13:0];
                REG_WINDOW:    cfg_reg.shake_window_us      <= cfg_data[31:0];
                REG_PEAKS:     cfg_reg.shake_peaks_needed   <= cfg_data[3:0];
                REG_LIFT:      cfg_reg.lift_samples_needed  <= cfg_data[7:0];
                REG_REARM:     cfg_reg.still_samples_rearm  <= cfg_data[7:0];
                REG_COOLDOWN:  cfg_reg.cooldown_us          <= cfg_data[39:0];
                default: ;
            endcase
        end
    end

    mgd_front #(
        .SAMPLE_BITS (SB),
        .TIME_BITS   (TB)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_x       (s_tdata[SB-1:0]),
        .s_y       (s_tdata[2*SB-1:SB]),
        .s_z       (s_tdata[3*SB-1:2*SB]),
        .s_now     (s_tdata[3*SB+TB-1:3*SB]),
        .s_supp    (s_tuser[0]),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    mgd_fifo #(
        .WIDTH (TB + 2),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (q_valid)
    );

    mgd_back #(
        .PEAK_SLOTS (PEAK_SLOTS),
        .TIME_BITS  (TB)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_gesture (gesture),
        .m_moving  (moving)
    );

    assign m_tdata = {6'd0, gesture};
    assign m_tuser = moving;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import mgd_pkg::*;

    localparam int RING_SLOTS  = 8;
    localparam int STALL_LIMIT = 4000;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [47:0]        stamp;
        logic               suppress;
    } sample_t;

    typedef struct {
        logic [1:0] gesture;
        logic       moving;
    } verdict_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [95:0]           s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    // detector state as the checker sees it
    cfg_t               model_cfg = CFG_RESET;
    logic signed [15:0] last_x = '0;
    logic signed [15:0] last_y = '0;
    logic signed [15:0] last_z = '0;
    bit                 have_last = 1'b0;
    int unsigned        quiet_run = 0;
    int unsigned        motion_run = 0;
    bit                 ready_arm = 1'b1;
    logic [47:0]        peak_ts [RING_SLOTS] = '{default: '0};
    bit                 peak_ok [RING_SLOTS] = '{default: 1'b0};
    int unsigned        ring_ptr = 0;
    logic [47:0]        trig_ts = '0;
    bit                 trig_seen = 1'b0;

    verdict_t    pending [$];
    int unsigned fault_count = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_tick = 0;
    int unsigned stall_period = 1;
    int unsigned stall_duty = 1;
    logic [47:0] stamp_us = '0;

    motion_gesture_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint unsigned sq(longint d);
        return d * d;
    endfunction

    function automatic void wipe_peaks();
        foreach (peak_ok[i]) begin
            peak_ok[i] = 1'b0;
            peak_ts[i] = '0;
        end
    endfunction

    function automatic void report_fault(string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // Advances the detector state by one sample and returns its result.
    function automatic verdict_t classify_sample(sample_t s);
        longint unsigned thr;
        longint unsigned grav;
        longint unsigned mag2;
        longint unsigned d2;
        longint unsigned hi;
        longint unsigned lo;
        logic [47:0]     age;
        int unsigned     hits;
        bit              blocked;
        verdict_t        v;
        thr = model_cfg.motion_threshold_lsb;
        grav = model_cfg.gravity_lsb;
        v.gesture = GEST_NONE;
        v.moving = 1'b0;
        mag2 = sq(s.ax) + sq(s.ay) + sq(s.az);
        if (have_last) begin
            d2 = sq(longint'(s.ax) - longint'(last_x)) + sq(longint'(s.ay) - longint'(last_y))
                 + sq(longint'(s.az) - longint'(last_z));
            if (d2 > thr * thr) v.moving = 1'b1;
        end
        hi = grav + thr;
        if (mag2 > hi * hi) v.moving = 1'b1;
        // no lower magnitude bound once the threshold reaches 1 g
        if (grav > thr) begin
            lo = grav - thr;
            if (mag2 < lo * lo) v.moving = 1'b1;
        end
        last_x = s.ax;
        last_y = s.ay;
        last_z = s.az;
        have_last = 1'b1;

        if (!v.moving) begin
            if (quiet_run < 255) quiet_run++;
            if (quiet_run >= model_cfg.still_samples_rearm) ready_arm = 1'b1;
            motion_run = 0;
            wipe_peaks();
        end else begin
            quiet_run = 0;
            age = s.stamp - trig_ts;
            blocked = s.suppress || !ready_arm || (trig_seen && age < model_cfg.cooldown_us);
            if (!blocked) begin
                peak_ts[ring_ptr] = s.stamp;
                peak_ok[ring_ptr] = 1'b1;
                ring_ptr = (ring_ptr + 1) % RING_SLOTS;
                hits = 0;
                for (int i = 0; i < RING_SLOTS; i++) begin
                    age = s.stamp - peak_ts[i];
                    if (peak_ok[i] && age < model_cfg.shake_window_us) hits++;
                end
                if (hits >= model_cfg.shake_peaks_needed) begin
                    ready_arm = 1'b0;
                    motion_run = 0;
                    trig_ts = s.stamp;
                    trig_seen = 1'b1;
                    wipe_peaks();
                    v.gesture = GEST_SHAKE;
                end else begin
                    if (motion_run < 255) motion_run++;
                    if (motion_run >= model_cfg.lift_samples_needed) begin
                        ready_arm = 1'b0;
                        motion_run = 0;
                        trig_ts = s.stamp;
                        trig_seen = 1'b1;
                        v.gesture = GEST_LIFT;
                    end
                end
            end
        end
        return v;
    endfunction

    function automatic sample_t make_sample(int x, int y, int z, logic [47:0] t, bit sup);
        sample_t s;
        s.ax = 16'(x);
        s.ay = 16'(y);
        s.az = 16'(z);
        s.stamp = t;
        s.suppress = sup;
        return s;
    endfunction

    // at rest: gravity on one axis, jitter well under the threshold
    function automatic sample_t calm_sample(logic [47:0] t, int axis, bit neg);
        int j;
        int g;
        int v [3];
        j = model_cfg.motion_threshold_lsb / 8;
        g = int'(model_cfg.gravity_lsb);
        foreach (v[k]) v[k] = int'($urandom_range(0, 2 * j)) - j;
        v[axis] += neg ? -g : g;
        return make_sample(v[0], v[1], v[2], t, $urandom_range(0, 7) == 0);
    endfunction

    function automatic sample_t jolt_sample(logic [47:0] t);
        return make_sample(int'($urandom), int'($urandom), int'($urandom), t,
                           $urandom_range(0, 7) == 0);
    endfunction

    task automatic send_sample(sample_t s);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 32);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tdata <= {s.stamp, s.az, s.ay, s.ax};
        s_tuser <= s.suppress;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
        pending.push_back(classify_sample(s));
    endtask

    // hold off the sender until every result is back
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_addr <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_THRESHOLD: model_cfg.motion_threshold_lsb = val[13:0];
            REG_GRAVITY:   model_cfg.gravity_lsb = val[13:0];
            REG_WINDOW:    model_cfg.shake_window_us = val[31:0];
            REG_PEAKS:     model_cfg.shake_peaks_needed = val[3:0];
            REG_LIFT:      model_cfg.lift_samples_needed = val[7:0];
            REG_REARM:     model_cfg.still_samples_rearm = val[7:0];
            REG_COOLDOWN:  model_cfg.cooldown_us = val[39:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(cfg_t c);
        write_reg(REG_THRESHOLD, 40'(c.motion_threshold_lsb));
        write_reg(REG_GRAVITY, 40'(c.gravity_lsb));
        write_reg(REG_WINDOW, 40'(c.shake_window_us));
        write_reg(REG_PEAKS, 40'(c.shake_peaks_needed));
        write_reg(REG_LIFT, 40'(c.lift_samples_needed));
        write_reg(REG_REARM, 40'(c.still_samples_rearm));
        write_reg(REG_COOLDOWN, c.cooldown_us);
        // unmapped index must not disturb anything
        write_reg(REG_SPARE, 40'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_episodes(int unsigned budget, int unsigned step_max);
        int unsigned stop;
        int unsigned k;
        int          axis;
        bit          neg;
        stop = items_sent + budget;
        while (items_sent < stop) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // usually long enough at rest to re-arm
                    k = $urandom_range(1, model_cfg.still_samples_rearm + 3);
                    axis = $urandom_range(0, 2);
                    neg = 1'($urandom_range(0, 1));
                    repeat (k) begin
                        stamp_us += $urandom_range(1, step_max);
                        send_sample(calm_sample(stamp_us, axis, neg));
                    end
                end
                3, 4, 5: begin
                    // tight cluster of peaks
                    repeat ($urandom_range(1, 10)) begin
                        stamp_us += $urandom_range(0, step_max / 4);
                        send_sample(jolt_sample(stamp_us));
                    end
                end
                6, 7: begin
                    // spaced past the window: only one peak at a time is ever inside it
                    repeat ($urandom_range(1, 12)) begin
                        stamp_us += 48'(model_cfg.shake_window_us) + $urandom_range(1, step_max);
                        send_sample(jolt_sample(stamp_us));
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(0, 2))
                            0: stamp_us = 48'({$urandom, $urandom});
                            1: stamp_us = 48'hFFFF_FFFF_F000 + $urandom_range(0, 8191);
                            default: stamp_us -= $urandom_range(0, step_max);
                        endcase
                        if ($urandom_range(0, 1) == 1) begin
                            send_sample(jolt_sample(stamp_us));
                        end else begin
                            send_sample(calm_sample(stamp_us, $urandom_range(0, 2),
                                                    1'($urandom_range(0, 1))));
                        end
                    end
                end
            endcase
        end
    endtask

    // register defaults straight out of reset
    task automatic test_reset_values();
        send_sample(make_sample(0, 0, 4096, 48'd0, 1'b0));
        send_sample(make_sample(0, 0, 5325, 48'd100000, 1'b0));
        send_sample(make_sample(0, 0, 5326, 48'd200000, 1'b0));
        send_sample(make_sample(0, 0, 2867, 48'd300000, 1'b0));
        send_sample(make_sample(-32768, -32768, -32768, 48'd400000, 1'b0));
        send_sample(make_sample(32767, 32767, 32767, 48'd500000, 1'b1));
        send_sample(make_sample(0, 0, 2866, 48'd600000, 1'b0));
        send_sample(make_sample(0, 0, -4096, 48'd700000, 1'b0));
        send_sample(make_sample(0, 0, -4096, 48'hFFFF_FFFF_FFFF, 1'b0));
        send_sample(make_sample(0, 4096, 0, 48'd5, 1'b0));
        send_sample(make_sample(0, 4096, 0, 48'd3, 1'b1));
        send_sample(make_sample(4096, 0, 0, 48'd0, 1'b0));
    endtask

    // lift trigger, disarm, re-arm and cooldown lockout
    task automatic test_lift_cooldown();
        cfg_t        c;
        logic [47:0] t;
        c = CFG_RESET;
        c.shake_window_us = 32'd1000;
        c.shake_peaks_needed = 4'd8;
        c.lift_samples_needed = 8'd2;
        c.still_samples_rearm = 8'd1;
        c.cooldown_us = 40'd5000;
        settle_idle();
        program_regs(c);
        t = 48'd1_000_000_000;
        send_sample(make_sample(0, 0, 4096, t, 1'b0));
        send_sample(make_sample(3000, 0, 4096, t + 10000, 1'b0));
        send_sample(make_sample(-3000, 0, 4096, t + 20000, 1'b0));
        send_sample(make_sample(3000, 0, 4096, t + 21000, 1'b0));
        send_sample(make_sample(0, 0, 4096, t + 21500, 1'b0));
        send_sample(make_sample(0, 0, 4096, t + 22000, 1'b0));
        send_sample(make_sample(3000, 0, 4096, t + 23000, 1'b0));
        send_sample(make_sample(0, 0, 4096, t + 24000, 1'b0));
        send_sample(make_sample(0, 0, 4096, t + 25000, 1'b0));
        send_sample(make_sample(3000, 0, 4096, t + 30000, 1'b1));
        send_sample(make_sample(-3000, 0, 4096, t + 35000, 1'b0));
        send_sample(make_sample(3000, 0, 4096, t + 40000, 1'b0));
        stamp_us = t + 40000;
    endtask

    task automatic test_register_extremes();
        cfg_t c;
        c = '{motion_threshold_lsb: 14'd0, gravity_lsb: 14'd1, shake_window_us: 32'd0,
              shake_peaks_needed: 4'd8, lift_samples_needed: 8'd255,
              still_samples_rearm: 8'd255, cooldown_us: 40'hFF_FFFF_FFFF};
        settle_idle();
        program_regs(c);
        run_episodes(100, 1000);
        c = '{motion_threshold_lsb: 14'h3FFF, gravity_lsb: 14'h3FFF,
              shake_window_us: 32'hFFFF_FFFF, shake_peaks_needed: 4'd1,
              lift_samples_needed: 8'd1, still_samples_rearm: 8'd1, cooldown_us: 40'd0};
        settle_idle();
        program_regs(c);
        run_episodes(120, 32'd1 << 30);
    endtask

    task automatic test_random_configs();
        cfg_t c;
        for (int p = 0; p < 10; p++) begin
            c.motion_threshold_lsb = 14'(($urandom_range(0, 4) == 0) ?
                $urandom_range(0, 16383) : $urandom_range(150, 2500));
            c.gravity_lsb = 14'(($urandom_range(0, 4) == 0) ?
                $urandom_range(1, 16383) : $urandom_range(1000, 12000));
            c.shake_window_us = 32'($urandom_range(1000, 2000000));
            c.shake_peaks_needed = 4'($urandom_range(1, 8));
            c.lift_samples_needed = 8'(($urandom_range(0, 3) == 0) ?
                $urandom_range(1, 255) : $urandom_range(1, 8));
            c.still_samples_rearm = 8'(($urandom_range(0, 3) == 0) ?
                $urandom_range(1, 255) : $urandom_range(1, 8));
            c.cooldown_us = ($urandom_range(0, 2) == 0) ?
                40'd0 : 40'($urandom_range(0, 3 * c.shake_window_us));
            settle_idle();
            program_regs(c);
            run_episodes(150, c.shake_window_us / 4 + 1);
        end
    endtask

    // result check and receiver stall pattern
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending.size() == 0) begin
                report_fault($sformatf("result beat with nothing pending: gesture %0d moving %0d",
                                       m_tdata[1:0], m_tuser[0]));
            end else begin
                want = pending.pop_front();
                if (m_tdata[1:0] !== want.gesture) begin
                    report_fault($sformatf("gesture mismatch: expected %0d, got %0d",
                                           want.gesture, m_tdata[1:0]));
                end
                if (m_tuser[0] !== want.moving) begin
                    report_fault($sformatf("moving mismatch: expected %0d, got %0d",
                                           want.moving, m_tuser[0]));
                end
            end
        end
        stall_tick++;
        if (stall_tick >= stall_period) begin
            stall_tick = 0;
            if ($urandom_range(0, 3) == 0) begin
                stall_period = $urandom_range(16, 64);
                stall_duty = stall_period;
            end else begin
                stall_period = $urandom_range(1, 9);
                stall_duty = $urandom_range(1, stall_period);
            end
        end
        m_tready <= (stall_tick < stall_duty);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        cfg_valid <= 1'b0;
        cfg_addr <= '0;
        cfg_data <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_lift_cooldown();
        test_register_extremes();
        test_random_configs();
        settle_idle();
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ motion_gesture_detector.f @@
rtl/mgd_pkg.sv
rtl/mgd_fifo.sv
rtl/mgd_front.sv
rtl/mgd_back.sv
rtl/motion_gesture_detector.sv
tb/testbench.sv
